// File: design/kvps_pkg.sv
// ----------------------------------------------------------------------------
// kvps_pkg
// Shared widths, codes and controller/datapath interface types for the
// pooled-score KV cache evictor.
// ----------------------------------------------------------------------------
package kvps_pkg;

  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 6;
  localparam int SCORE_W    = 16;
  localparam int SUM_W      = 20;
  localparam int POS_W      = 32;
  localparam int BUDGET_W   = 32;
  localparam int ROOM_W     = 7;
  localparam int SHARE_W    = 7;
  localparam int PROT_W     = 6;
  localparam int WIN_W      = 5;
  localparam int POOL_W     = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [KIND_W-1:0] KIND_ATTN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_SHARE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_WIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_HALF   = 4'd3;

  localparam logic [ROOM_W-1:0] ROOM_MAX = 7'd64;

  typedef struct packed {
    logic attn_write;
    logic append_do;
    logic evict_setup;
    logic clear_write;
    logic pos_zero;
    logic sum_read;
    logic sum_acc;
    logic pool_start;
    logic pool_read;
    logic pool_acc;
    logic sel_start;
    logic sel_read;
    logic sel_cmp;
    logic sel_mark;
    logic cmp_start;
    logic cmp_check;
    logic cmp_emit;
    logic cmp_keep;
    logic cmp_skip;
    logic copy_read;
    logic copy_write;
    logic finish;
    logic emit_none;
  } kvps_cmd_t;

  typedef struct packed {
    logic out_free;
    logic append_room;
    logic evict_none;
    logic row_done;
    logic sum_col_last;
    logic sum_row_last;
    logic pool_j_last;
    logic pool_i_last;
    logic sel_last;
    logic sel_done;
    logic cmp_marked;
    logic cmp_move;
    logic cmp_last;
  } kvps_status_t;

endpackage

// File: design/kvps_ctrl.sv
// ----------------------------------------------------------------------------
// kvps_ctrl
// Sequencer for the evictor: decodes requests and steps the datapath through
// row clearing, summing, pooling, victim selection and compaction.
// ----------------------------------------------------------------------------
module kvps_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [kvps_pkg::KIND_W-1:0]  kind,
  output logic                         in_stall,
  input  kvps_pkg::kvps_status_t       sts,
  output kvps_pkg::kvps_cmd_t          cmd
);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_EV_DECIDE, ST_EV_NONE,
    ST_SUM_RD, ST_SUM_ACC, ST_POOL_RD, ST_POOL_ACC,
    ST_SEL_RD, ST_SEL_CMP, ST_SEL_MARK,
    ST_CMP_CHECK, ST_CMP_POS, ST_COPY_RD, ST_COPY_WR, ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.clear_write = 1'b1;
        cmd.pos_zero    = 1'b1;
        if (sts.row_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            kvps_pkg::KIND_ATTN: cmd.attn_write = 1'b1;
            kvps_pkg::KIND_APPEND: begin
              cmd.append_do = 1'b1;
              if (sts.append_room) state_next = ST_CLEAR;
            end
            kvps_pkg::KIND_EVICT: begin
              cmd.evict_setup = 1'b1;
              state_next      = ST_EV_DECIDE;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (sts.row_done) state_next = ST_IDLE;
      end
      ST_EV_DECIDE: begin
        state_next = sts.evict_none ? ST_EV_NONE : ST_SUM_RD;
      end
      ST_EV_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_SUM_RD: begin
        cmd.sum_read = 1'b1;
        state_next   = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (sts.sum_col_last && sts.sum_row_last) begin
          cmd.pool_start = 1'b1;
          state_next     = ST_POOL_RD;
        end else begin
          state_next = ST_SUM_RD;
        end
      end
      ST_POOL_RD: begin
        cmd.pool_read = 1'b1;
        state_next    = ST_POOL_ACC;
      end
      ST_POOL_ACC: begin
        cmd.pool_acc = 1'b1;
        if (sts.pool_j_last && sts.pool_i_last) begin
          cmd.sel_start = 1'b1;
          state_next    = ST_SEL_RD;
        end else begin
          state_next = ST_POOL_RD;
        end
      end
      ST_SEL_RD: begin
        cmd.sel_read = 1'b1;
        state_next   = ST_SEL_CMP;
      end
      ST_SEL_CMP: begin
        cmd.sel_cmp = 1'b1;
        state_next  = sts.sel_last ? ST_SEL_MARK : ST_SEL_RD;
      end
      ST_SEL_MARK: begin
        cmd.sel_mark = 1'b1;
        if (sts.sel_done) begin
          cmd.cmp_start = 1'b1;
          state_next    = ST_CMP_CHECK;
        end else begin
          state_next = ST_SEL_RD;
        end
      end
      ST_CMP_CHECK: begin
        cmd.cmp_check = 1'b1;
        state_next    = ST_CMP_POS;
      end
      ST_CMP_POS: begin
        if (sts.cmp_marked) begin
          if (sts.out_free) begin
            cmd.cmp_emit = 1'b1;
            state_next   = sts.cmp_last ? ST_FINISH : ST_CMP_CHECK;
          end
        end else if (sts.cmp_move) begin
          cmd.cmp_keep = 1'b1;
          state_next   = ST_COPY_RD;
        end else begin
          cmd.cmp_skip = 1'b1;
          state_next   = sts.cmp_last ? ST_FINISH : ST_CMP_CHECK;
        end
      end
      ST_COPY_RD: begin
        cmd.copy_read = 1'b1;
        state_next    = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_write = 1'b1;
        if (sts.row_done) begin
          state_next = sts.cmp_last ? ST_FINISH : ST_CMP_CHECK;
        end else begin
          state_next = ST_COPY_RD;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/kvps_datapath.sv
// ----------------------------------------------------------------------------
// kvps_datapath
// Configuration registers, table memories, loop counters, the sum and pool
// accumulators, the minimum search and the result register.
// ----------------------------------------------------------------------------
module kvps_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int RING_DEPTH  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kvps_pkg::kvps_cmd_t              cmd,
  output kvps_pkg::kvps_status_t           sts,
  input  logic                             cfg_valid,
  input  logic [kvps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [kvps_pkg::INDEX_W-1:0]     entry_index,
  input  logic [kvps_pkg::SCORE_W-1:0]     attention_value,
  input  logic                             attention_given,
  input  logic [kvps_pkg::POS_W-1:0]       position,
  input  logic [kvps_pkg::BUDGET_W-1:0]    caller_budget,
  input  logic [kvps_pkg::ROOM_W-1:0]      victim_room,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kvps_pkg::POS_W-1:0]       victim_position,
  output logic                             victim_valid,
  output logic                             last_victim
);

  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int CNTW      = $clog2(TABLE_DEPTH + 1);
  localparam int CW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_SIZE = TABLE_DEPTH * RING_DEPTH;
  localparam int AW        = $clog2(RING_SIZE);

  function automatic logic [AW-1:0] ring_addr(input logic [IW-1:0] row,
                                               input logic [CW-1:0] col);
    ring_addr = AW'(row) * AW'(RING_DEPTH) + AW'(col);
  endfunction

  // Configuration.
  logic [kvps_pkg::SHARE_W-1:0] layer_share;
  logic [kvps_pkg::PROT_W-1:0]  protect_window;
  logic [kvps_pkg::WIN_W-1:0]   score_window;
  logic [kvps_pkg::POOL_W-1:0]  pool_half_width;

  // Control state.
  logic [CNTW-1:0] count;
  logic [CW-1:0]   ring_col;
  logic [CNTW-1:0] i_cnt;
  logic [CW-1:0]   col_cnt;
  logic [IW-1:0]   j_cnt;
  logic [CNTW-1:0] wr_cnt;
  logic [CNTW-1:0] taken;
  logic [CNTW-1:0] emitted;
  logic [TABLE_DEPTH-1:0] marks;

  // Payload state.
  logic [CNTW-1:0]  needed;
  logic [CNTW-1:0]  end_n;
  logic             none_r;
  logic [kvps_pkg::SUM_W-1:0] acc;
  logic [kvps_pkg::SUM_W-1:0] best;
  logic [IW-1:0]    pick;
  logic             found;

  // Memories.
  logic [kvps_pkg::SCORE_W-1:0] ring_mem [RING_SIZE];
  logic [kvps_pkg::POS_W-1:0]   pos_mem  [TABLE_DEPTH];
  logic [kvps_pkg::SUM_W-1:0]   sum_mem  [TABLE_DEPTH];
  logic [kvps_pkg::SUM_W-1:0]   pool_mem [TABLE_DEPTH];
  logic [kvps_pkg::SCORE_W-1:0] ring_q;
  logic [kvps_pkg::POS_W-1:0]   pos_q;
  logic [kvps_pkg::SUM_W-1:0]   sum_q;
  logic [kvps_pkg::SUM_W-1:0]   pool_q;

  logic                          ring_we;
  logic [AW-1:0]                 ring_waddr;
  logic [kvps_pkg::SCORE_W-1:0]  ring_wdata;
  logic                          pos_we;
  logic [IW-1:0]                 pos_waddr;
  logic [kvps_pkg::POS_W-1:0]    pos_wdata;

  // Derived values.
  logic [kvps_pkg::WIN_W-1:0]   win_act;
  logic [kvps_pkg::WIN_W-1:0]   col_inc;
  logic [CW-1:0]                col_adv;
  logic [7:0]                   cnt8;
  logic [7:0]                   i8;
  logic [7:0]                   r8;
  logic [kvps_pkg::SHARE_W-1:0] target;
  logic [7:0]                   tgt8;
  logic [7:0]                   prot8;
  logic [7:0]                   end8;
  logic [7:0]                   need8;
  logic [7:0]                   needc;
  logic [7:0]                   room8;
  logic                         none_now;
  logic [kvps_pkg::SUM_W-1:0]   acc_new;
  logic [7:0]                   lo_i;
  logic [7:0]                   lo_n;
  logic [7:0]                   hi_i;
  logic [kvps_pkg::SUM_W-1:0]   best_new;
  logic                         cand;
  logic                         attn_hit;
  logic                         emit_last;

  always_comb begin
    if (score_window == '0) begin
      win_act = kvps_pkg::WIN_W'(1);
    end else if (score_window > kvps_pkg::WIN_W'(RING_DEPTH)) begin
      win_act = kvps_pkg::WIN_W'(RING_DEPTH);
    end else begin
      win_act = score_window;
    end
  end

  // A column beyond a shrunken window wraps to zero on the next advance.
  assign col_inc = kvps_pkg::WIN_W'(ring_col) + kvps_pkg::WIN_W'(1);
  assign col_adv = (col_inc >= win_act) ? '0 : col_inc[CW-1:0];

  assign cnt8 = 8'(count);
  assign i8   = 8'(i_cnt);
  assign r8   = 8'(pool_half_width);

  always_comb begin
    target = (caller_budget < kvps_pkg::BUDGET_W'(layer_share)) ?
             caller_budget[kvps_pkg::SHARE_W-1:0] : layer_share;
    tgt8   = 8'(target);
    prot8  = (8'(protect_window) < cnt8) ? 8'(protect_window) : cnt8;
    end8   = cnt8 - prot8;
    need8  = cnt8 - tgt8;
    needc  = (need8 > end8) ? end8 : need8;
    room8  = (victim_room > kvps_pkg::ROOM_MAX) ? 8'(kvps_pkg::ROOM_MAX) : 8'(victim_room);
    none_now = (cnt8 <= tgt8) || (needc == 8'd0) || (needc > room8);
  end

  assign acc_new = ((col_cnt == '0) ? '0 : acc) + kvps_pkg::SUM_W'(ring_q);

  always_comb begin
    lo_i = (i8 < r8) ? 8'd0 : i8 - r8;
    lo_n = ((i8 + 8'd1) < r8) ? 8'd0 : i8 + 8'd1 - r8;
    hi_i = ((i8 + r8) > (cnt8 - 8'd1)) ? cnt8 - 8'd1 : i8 + r8;
    if (8'(j_cnt) == lo_i) begin
      best_new = sum_q;
    end else begin
      best_new = (sum_q > best) ? sum_q : best;
    end
  end

  // Strict compare keeps the lower index on ties.
  assign cand      = !marks[i_cnt[IW-1:0]] && (!found || (pool_q < best));
  assign attn_hit  = 8'(entry_index) < cnt8;
  assign emit_last = (8'(emitted) + 8'd1) == 8'(needed);

  always_comb begin
    sts.out_free     = !out_valid || !out_stall;
    sts.append_room  = cnt8 < 8'(TABLE_DEPTH);
    sts.evict_none   = none_r;
    sts.row_done     = col_cnt == CW'(RING_DEPTH - 1);
    sts.sum_col_last = kvps_pkg::WIN_W'(col_cnt) == (win_act - kvps_pkg::WIN_W'(1));
    sts.sum_row_last = (i8 + 8'd1) == cnt8;
    sts.pool_j_last  = 8'(j_cnt) == hi_i;
    sts.pool_i_last  = (i8 + 8'd1) == cnt8;
    sts.sel_last     = (i8 + 8'd1) == 8'(end_n);
    sts.sel_done     = (8'(taken) + 8'd1) == 8'(needed);
    sts.cmp_marked   = marks[i_cnt[IW-1:0]];
    sts.cmp_move     = wr_cnt != i_cnt;
    sts.cmp_last     = (i8 + 8'd1) == cnt8;
  end

  // Ring write port.
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = ring_addr(i_cnt[IW-1:0], col_cnt);
    ring_wdata = '0;
    if (cmd.attn_write && attn_hit) begin
      ring_we    = 1'b1;
      ring_waddr = ring_addr(entry_index[IW-1:0], ring_col);
      ring_wdata = attention_value;
    end else if (cmd.clear_write) begin
      ring_we = 1'b1;
    end else if (cmd.copy_write) begin
      ring_we    = 1'b1;
      ring_waddr = ring_addr(wr_cnt[IW-1:0], col_cnt);
      ring_wdata = ring_q;
    end
  end

  // Position write port.
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = i_cnt[IW-1:0];
    pos_wdata = '0;
    if (cmd.append_do && sts.append_room) begin
      pos_we    = 1'b1;
      pos_waddr = count[IW-1:0];
      pos_wdata = position;
    end else if (cmd.pos_zero) begin
      pos_we = 1'b1;
    end else if (cmd.cmp_keep) begin
      pos_we    = 1'b1;
      pos_waddr = wr_cnt[IW-1:0];
      pos_wdata = pos_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_q <= ring_mem[ring_addr(i_cnt[IW-1:0], col_cnt)];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_q <= pos_mem[i_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_acc && sts.sum_col_last) sum_mem[i_cnt[IW-1:0]] <= acc_new;
    sum_q <= sum_mem[j_cnt];
  end

  always_ff @(posedge clk) begin
    if (cmd.pool_acc && sts.pool_j_last) pool_mem[i_cnt[IW-1:0]] <= best_new;
    pool_q <= pool_mem[i_cnt[IW-1:0]];
  end

  // Control registers; later commands in the same cycle override earlier ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_share     <= kvps_pkg::SHARE_W'(64);
      protect_window  <= kvps_pkg::PROT_W'(32);
      score_window    <= kvps_pkg::WIN_W'(16);
      pool_half_width <= kvps_pkg::POOL_W'(3);
      count           <= CNTW'(1);
      ring_col        <= '0;
      i_cnt           <= '0;
      col_cnt         <= '0;
      j_cnt           <= '0;
      wr_cnt          <= '0;
      taken           <= '0;
      emitted         <= '0;
      marks           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          kvps_pkg::CFG_LAYER_SHARE: layer_share     <= cfg_data;
          kvps_pkg::CFG_PROTECT:     protect_window  <= cfg_data[kvps_pkg::PROT_W-1:0];
          kvps_pkg::CFG_SCORE_WIN:   score_window    <= cfg_data[kvps_pkg::WIN_W-1:0];
          kvps_pkg::CFG_POOL_HALF:   pool_half_width <= cfg_data[kvps_pkg::POOL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.append_do) begin
        if (attention_given) ring_col <= col_adv;
        if (sts.append_room) begin
          count   <= count + CNTW'(1);
          i_cnt   <= count;
          col_cnt <= '0;
        end
      end
      if (cmd.clear_write) col_cnt <= sts.row_done ? '0 : col_cnt + CW'(1);
      if (cmd.evict_setup) begin
        i_cnt   <= '0;
        col_cnt <= '0;
        taken   <= '0;
        emitted <= '0;
      end
      if (cmd.sum_acc) begin
        if (sts.sum_col_last) begin
          col_cnt <= '0;
          i_cnt   <= i_cnt + CNTW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (cmd.pool_start) begin
        i_cnt <= '0;
        j_cnt <= '0;
      end
      if (cmd.pool_acc) begin
        if (sts.pool_j_last) begin
          i_cnt <= i_cnt + CNTW'(1);
          j_cnt <= lo_n[IW-1:0];
        end else begin
          j_cnt <= j_cnt + IW'(1);
        end
      end
      if (cmd.sel_start) i_cnt <= '0;
      if (cmd.sel_cmp) i_cnt <= i_cnt + CNTW'(1);
      if (cmd.sel_mark) begin
        marks[pick] <= 1'b1;
        taken       <= taken + CNTW'(1);
        i_cnt       <= '0;
      end
      if (cmd.cmp_start) begin
        i_cnt  <= '0;
        wr_cnt <= '0;
      end
      if (cmd.cmp_emit) begin
        marks[i_cnt[IW-1:0]] <= 1'b0;
        emitted              <= emitted + CNTW'(1);
        i_cnt                <= i_cnt + CNTW'(1);
        out_valid            <= 1'b1;
      end
      if (cmd.cmp_keep) col_cnt <= '0;
      if (cmd.cmp_skip) begin
        i_cnt  <= i_cnt + CNTW'(1);
        wr_cnt <= wr_cnt + CNTW'(1);
      end
      if (cmd.copy_write) begin
        if (sts.row_done) begin
          col_cnt <= '0;
          i_cnt   <= i_cnt + CNTW'(1);
          wr_cnt  <= wr_cnt + CNTW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (cmd.finish) count <= wr_cnt;
      if (cmd.emit_none) out_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.evict_setup) begin
      needed <= CNTW'(needc);
      end_n  <= CNTW'(end8);
      none_r <= none_now;
    end
    if (cmd.sum_acc) acc <= acc_new;
    if (cmd.pool_acc) best <= best_new;
    if (cmd.sel_start || cmd.sel_mark) found <= 1'b0;
    if (cmd.sel_cmp && cand) begin
      pick  <= i_cnt[IW-1:0];
      best  <= pool_q;
      found <= 1'b1;
    end
    if (cmd.cmp_emit) begin
      victim_position <= pos_q;
      victim_valid    <= 1'b1;
      last_victim     <= emit_last;
    end
    if (cmd.emit_none) begin
      victim_position <= '0;
      victim_valid    <= 1'b0;
      last_victim     <= 1'b1;
    end
  end

endmodule

// File: design/kv_cache_pooled_score_evictor.sv
// ----------------------------------------------------------------------------
// kv_cache_pooled_score_evictor
// Tracks cached token positions with per-entry attention score rings and
// evicts the entries with the lowest max-pooled ring sums on request.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall: kind 0 writes one attention score,
// kind 1 appends a token, kind 2 asks for an eviction; kind 3 is dropped.
// Results leave on out_valid/out_stall, only for evictions: one per victim
// in table order with last_victim on the final one, or a single result with
// victim_valid low when nothing is evicted. Registers are written on the
// cfg_valid/cfg_ready port, which is always ready; write them only while idle.
// An attention score write leaves in_stall low; an append that finds room holds
// in_stall while it clears the new ring row through the single ring write port.
// An eviction walks the table through one memory port per phase: the ring
// sums, max pooling, one selection pass per victim, then compaction, which
// checks every entry and copies each moved row.
// After reset the block clears ring row 0 while holding in_stall high.
// A stalled result is held in the output register; compaction waits on
// it, and an idle block still accepts requests behind it.
// ----------------------------------------------------------------------------
module kv_cache_pooled_score_evictor #(
  parameter int TABLE_DEPTH = 64,
  parameter int RING_DEPTH  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kvps_pkg::KIND_W-1:0]      kind,
  input  logic [kvps_pkg::INDEX_W-1:0]     entry_index,
  input  logic [kvps_pkg::SCORE_W-1:0]     attention_value,
  input  logic                             attention_given,
  input  logic [kvps_pkg::POS_W-1:0]       position,
  input  logic [kvps_pkg::BUDGET_W-1:0]    caller_budget,
  input  logic [kvps_pkg::ROOM_W-1:0]      victim_room,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kvps_pkg::POS_W-1:0]       victim_position,
  output logic                             victim_valid,
  output logic                             last_victim,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kvps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kvps_pkg::kvps_cmd_t    cmd;
  kvps_pkg::kvps_status_t sts;

  assign cfg_ready = 1'b1;

  kvps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvps_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RING_DEPTH  (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .entry_index     (entry_index),
    .attention_value (attention_value),
    .attention_given (attention_given),
    .position        (position),
    .caller_budget   (caller_budget),
    .victim_room     (victim_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .victim_position (victim_position),
    .victim_valid    (victim_valid),
    .last_victim     (last_victim)
  );

endmodule

// File: design/kvps_checker.sv
// ----------------------------------------------------------------------------
// kvps_checker
// Port-level checks for the evictor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module kvps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [kvps_pkg::KIND_W-1:0]   kind,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kvps_pkg::POS_W-1:0]    victim_position,
  input logic                          victim_valid,
  input logic                          last_victim
);

  // The ring row clear after reset holds off requests.
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_stall)
    else $error("requests accepted during the post-reset clear");

  // A score write finishes in its own cycle.
  a_attn_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == kvps_pkg::KIND_ATTN |=> !in_stall)
    else $error("attention request did not complete in one cycle");

  // A no-victim result is always the last one and carries no position.
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !victim_valid |-> last_victim && victim_position == '0)
    else $error("malformed no-victim result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(victim_position) &&
      $stable(victim_valid) && $stable(last_victim))
    else $error("stalled result changed");

endmodule

bind kv_cache_pooled_score_evictor kvps_checker u_kvps_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .kind            (kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .victim_position (victim_position),
  .victim_valid    (victim_valid),
  .last_victim     (last_victim)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pooled-score KV cache evictor. A queue of
// requests is driven with random gaps; a behavioral copy of the table predicts
// victim reports, which are compared in order against the block's results.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the block ignores.
  localparam logic [kvps_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [kvps_pkg::KIND_W-1:0]   kind;
    logic [kvps_pkg::INDEX_W-1:0]  idx;
    logic [kvps_pkg::SCORE_W-1:0]  attn;
    logic                          given;
    logic [kvps_pkg::POS_W-1:0]    pos;
    logic [kvps_pkg::BUDGET_W-1:0] budget;
    logic [kvps_pkg::ROOM_W-1:0]   room;
  } req_t;

  typedef struct packed {
    logic [kvps_pkg::POS_W-1:0] pos;
    logic                       vld;
    logic                       last;
  } victim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [kvps_pkg::KIND_W-1:0] kind = '0;
  logic [kvps_pkg::INDEX_W-1:0] entry_index = '0;
  logic [kvps_pkg::SCORE_W-1:0] attention_value = '0;
  logic attention_given = 1'b0;
  logic [kvps_pkg::POS_W-1:0] position = '0;
  logic [kvps_pkg::BUDGET_W-1:0] caller_budget = '0;
  logic [kvps_pkg::ROOM_W-1:0] victim_room = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [kvps_pkg::POS_W-1:0] victim_position;
  logic victim_valid;
  logic last_victim;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kvps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kvps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  kv_cache_pooled_score_evictor dut (.*);

  always #5 clk = ~clk;

  // Shadow of the block state.
  logic [kvps_pkg::SHARE_W-1:0] m_share;
  logic [kvps_pkg::PROT_W-1:0]  m_prot;
  logic [kvps_pkg::WIN_W-1:0]   m_win;
  logic [kvps_pkg::POOL_W-1:0]  m_pool;
  logic [kvps_pkg::POS_W-1:0]   m_pos[64];
  logic [kvps_pkg::SCORE_W-1:0] m_ring[64][16];
  int                           m_count;
  int                           m_col;

  req_t    pending[$];
  victim_t victims_due[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      hold_off = 0;
  bit      allow_stall = 1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int ring_width();
    if (m_win == 0) return 1;
    if (m_win > 16) return 16;
    return m_win;
  endfunction

  function automatic void push_none();
    victim_t v;
    v.pos = '0;
    v.vld = 1'b0;
    v.last = 1'b1;
    victims_due.push_back(v);
  endfunction

  function automatic void predict_evict(logic [kvps_pkg::BUDGET_W-1:0] budget,
                                        logic [kvps_pkg::ROOM_W-1:0] room_in);
    longint target;
    int room, needed, prot, span_end, w, lo, hi, pick, wr, first;
    logic [kvps_pkg::SUM_W-1:0] sums[64];
    logic [kvps_pkg::SUM_W-1:0] pooled[64];
    bit marks[64];
    victim_t v;
    target = (budget < m_share) ? longint'(budget) : longint'(m_share);
    room = (room_in > 64) ? 64 : room_in;
    if (m_count <= target) begin
      push_none();
      return;
    end
    needed = m_count - int'(target);
    prot = (m_prot < m_count) ? m_prot : m_count;
    span_end = m_count - prot;
    if (needed > span_end) needed = span_end;
    if (needed == 0 || needed > room) begin
      push_none();
      return;
    end
    w = ring_width();
    for (int i = 0; i < m_count; i++) begin
      sums[i] = '0;
      for (int j = 0; j < w; j++) sums[i] += m_ring[i][j];
      marks[i] = 0;
    end
    for (int i = 0; i < m_count; i++) begin
      lo = (i < m_pool) ? 0 : i - m_pool;
      hi = (i + m_pool >= m_count) ? m_count - 1 : i + m_pool;
      pooled[i] = sums[lo];
      for (int j = lo + 1; j <= hi; j++) if (sums[j] > pooled[i]) pooled[i] = sums[j];
    end
    for (int t = 0; t < needed; t++) begin
      pick = -1;
      for (int i = 0; i < span_end; i++)
        if (!marks[i] && (pick < 0 || pooled[i] < pooled[pick])) pick = i;
      if (pick >= 0) marks[pick] = 1;
    end
    wr = 0;
    first = victims_due.size();
    for (int rd = 0; rd < m_count; rd++) begin
      if (marks[rd]) begin
        v.pos = m_pos[rd];
        v.vld = 1'b1;
        v.last = 1'b0;
        victims_due.push_back(v);
      end else begin
        m_pos[wr] = m_pos[rd];
        m_ring[wr] = m_ring[rd];
        wr++;
      end
    end
    m_count = wr;
    if (victims_due.size() > first) victims_due[victims_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void predict(req_t r);
    if (r.kind == kvps_pkg::KIND_ATTN) begin
      if (r.idx < m_count && m_col < 16) m_ring[r.idx][m_col] = r.attn;
    end else if (r.kind == kvps_pkg::KIND_APPEND) begin
      if (r.given) begin
        m_col++;
        if (m_col >= ring_width()) m_col = 0;
      end
      if (m_count < 64) begin
        for (int j = 0; j < 16; j++) m_ring[m_count][j] = '0;
        m_pos[m_count] = r.pos;
        m_count++;
      end
    end else if (r.kind == kvps_pkg::KIND_EVICT) begin
      predict_evict(r.budget, r.room);
    end
  endfunction

  function automatic req_t mk(logic [kvps_pkg::KIND_W-1:0] k);
    req_t r;
    r.kind = k;
    r.idx = kvps_pkg::INDEX_W'($urandom_range(0, 63));
    r.attn = kvps_pkg::SCORE_W'($urandom);
    r.given = 1'($urandom_range(0, 1));
    r.pos = $urandom;
    r.budget = $urandom;
    r.room = kvps_pkg::ROOM_W'($urandom_range(0, 127));
    return r;
  endfunction

  // Driver: one request offered at a time, random gaps between them.
  int gap = 0;
  always @(posedge clk) begin
    req_t acc_r;
    req_t nxt;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        acc_r = '{kind, entry_index, attention_value, attention_given, position,
                  caller_budget, victim_room};
        predict(acc_r);
        gap = gap_len();
      end
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          kind <= nxt.kind;
          entry_index <= nxt.idx;
          attention_value <= nxt.attn;
          attention_given <= nxt.given;
          position <= nxt.pos;
          caller_budget <= nxt.budget;
          victim_room <= nxt.room;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall.
  int rx_gap = 0;
  always @(posedge clk) begin
    victim_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (victims_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result pos=%h valid=%b last=%b",
                     victim_position, victim_valid, last_victim);
        end else begin
          e = victims_due.pop_front();
          if (e.pos !== victim_position || e.vld !== victim_valid ||
              e.last !== last_victim) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected pos=%h valid=%b last=%b, got pos=%h %s",
                       e.pos, e.vld, e.last, victim_position,
                       $sformatf("valid=%b last=%b", victim_valid, last_victim));
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0 && allow_stall) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        rx_gap = allow_stall ? gap_len() : 0;
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 400000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic settle();
    while (pending.size() > 0 || in_valid || victims_due.size() > 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  task automatic write_reg(logic [kvps_pkg::CFG_IDX_W-1:0] idx,
                           logic [kvps_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      kvps_pkg::CFG_LAYER_SHARE: m_share = val;
      kvps_pkg::CFG_PROTECT:     m_prot = val[kvps_pkg::PROT_W-1:0];
      kvps_pkg::CFG_SCORE_WIN:   m_win = val[kvps_pkg::WIN_W-1:0];
      kvps_pkg::CFG_POOL_HALF:   m_pool = val[kvps_pkg::POOL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Fill the table, score it, then evict; mostly well-formed sequences.
  task automatic queue_round(int appends, int attns);
    req_t r;
    for (int i = 0; i < appends; i++) begin
      r = mk(kvps_pkg::KIND_APPEND);
      pending.push_back(r);
      for (int k = 0; k < attns; k++) begin
        r = mk(kvps_pkg::KIND_ATTN);
        if ($urandom_range(0, 9) != 0) r.idx = kvps_pkg::INDEX_W'($urandom_range(0, i));
        pending.push_back(r);
      end
    end
    r = mk(kvps_pkg::KIND_EVICT);
    r.budget = $urandom_range(0, 40);
    r.room = ($urandom_range(0, 9) == 0) ? kvps_pkg::ROOM_W'($urandom_range(0, 127)) : 7'd64;
    pending.push_back(r);
  endtask

  initial begin
    req_t r;
    m_share = 64; m_prot = 32; m_win = 16; m_pool = 3;
    m_count = 1; m_col = 0;
    for (int i = 0; i < 64; i++) begin
      m_pos[i] = '0;
      for (int j = 0; j < 16; j++) m_ring[i][j] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small windows so evictions happen early.
    write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd3);
    write_reg(kvps_pkg::CFG_PROTECT, 7'd1);
    write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd2);
    write_reg(kvps_pkg::CFG_POOL_HALF, 7'd0);
    write_reg(4'd9, 7'h7f);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd64; pending.push_back(r);
    for (int i = 0; i < 6; i++) begin
      r = mk(kvps_pkg::KIND_APPEND);
      r.pos = (i == 0) ? 32'hffff_ffff : 32'(i);
      pending.push_back(r);
      r = mk(kvps_pkg::KIND_ATTN);
      r.idx = kvps_pkg::INDEX_W'(i);
      r.attn = (i == 2) ? 16'hffff : 16'h0000;
      pending.push_back(r);
    end
    r = mk(kvps_pkg::KIND_ATTN); r.idx = 6'd63; pending.push_back(r);
    r = mk(KIND_UNUSED); pending.push_back(r);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = 32'hffff_ffff; pending.push_back(r);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd0; pending.push_back(r);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd127; pending.push_back(r);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd64; pending.push_back(r);
    settle();

    // Column beyond a shrunken window, then extremes of every register.
    write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd16);
    r = mk(kvps_pkg::KIND_APPEND); r.given = 1'b1; pending.push_back(r);
    r = mk(kvps_pkg::KIND_APPEND); r.given = 1'b1; pending.push_back(r);
    r = mk(kvps_pkg::KIND_APPEND); r.given = 1'b1; pending.push_back(r);
    settle();
    write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd0);
    write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd1);
    write_reg(kvps_pkg::CFG_PROTECT, 7'd63);
    write_reg(kvps_pkg::CFG_POOL_HALF, 7'd31);
    r = mk(kvps_pkg::KIND_ATTN); r.idx = '0; pending.push_back(r);
    r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd64; pending.push_back(r);
    settle();

    // Random phases across several settings, with one long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      allow_stall = (ph != 2);
      case (ph)
        0: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd64); write_reg(kvps_pkg::CFG_PROTECT, 7'd0);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd17); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd1);
        end
        1: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd8); write_reg(kvps_pkg::CFG_PROTECT, 7'd2);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd4); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd2);
        end
        2: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd2); write_reg(kvps_pkg::CFG_PROTECT, 7'd0);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd1); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd0);
        end
        3: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd20); write_reg(kvps_pkg::CFG_PROTECT, 7'd3);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd31); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd5);
        end
        4: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd127); write_reg(kvps_pkg::CFG_PROTECT, 7'd4);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd3); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd31);
        end
        default: begin
          write_reg(kvps_pkg::CFG_LAYER_SHARE, 7'd10); write_reg(kvps_pkg::CFG_PROTECT, 7'd5);
          write_reg(kvps_pkg::CFG_SCORE_WIN, 7'd8); write_reg(kvps_pkg::CFG_POOL_HALF, 7'd3);
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        if (ph == 0 && k == 0) queue_round(66, 0);
        else queue_round($urandom_range(2, 10), $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
          pending.push_back(mk(kvps_pkg::KIND_W'($urandom_range(0, 3))));
      end
      if (ph == 3) begin
        hold_off = 3000;
        for (int k = 0; k < 3; k++) begin
          r = mk(kvps_pkg::KIND_EVICT); r.budget = '0; r.room = 7'd64; pending.push_back(r);
          r = mk(kvps_pkg::KIND_APPEND); pending.push_back(r);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: kv_cache_pooled_score_evictor.f
design/kvps_pkg.sv
design/kvps_ctrl.sv
design/kvps_datapath.sv
design/kv_cache_pooled_score_evictor.sv
design/kvps_checker.sv
tb/tb_top.sv
